// ===== design/mkscan_pkg.sv =====
// Shared constants, types and helper functions for the keypad line reversal scanner.
`timescale 1ns / 1ps
`default_nettype none
package mkscan_pkg;

    localparam int NUM_ROWS    = 5;
    localparam int NUM_COLUMNS = 4;

    localparam int ROW_W     = 5;
    localparam int COL_W     = 4;
    localparam int ROW_IDX_W = 3;
    localparam int COL_IDX_W = 2;
    localparam int HITS_W    = 8;
    localparam int CODE_W    = 5;
    localparam int RELEASE_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [HITS_W-1:0]    DEBOUNCE_RESET = 8'd10;
    localparam logic [RELEASE_W-1:0] RELEASE_RESET  = 16'd100;
    localparam logic [HITS_W-1:0]    HITS_MAX       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_LIMIT = 1'b0,
        REG_RELEASE_TICKS  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                 found;
        logic [ROW_IDX_W-1:0] index;
    } row_hit_t;

    typedef struct packed {
        logic                 found;
        logic [COL_IDX_W-1:0] index;
    } col_hit_t;

    // Lowest row line that is pulled low.
    function automatic row_hit_t lowest_low_row(input logic [ROW_W-1:0] levels);
        row_hit_t res;
        res = '0;
        for (int i = NUM_ROWS - 1; i >= 0; i--) begin
            if (!levels[i]) begin
                res.found = 1'b1;
                res.index = ROW_IDX_W'(i);
            end
        end
        return res;
    endfunction

    // Lowest column line that is pulled low.
    function automatic col_hit_t lowest_low_col(input logic [COL_W-1:0] levels);
        col_hit_t res;
        res = '0;
        for (int j = NUM_COLUMNS - 1; j >= 0; j--) begin
            if (!levels[j]) begin
                res.found = 1'b1;
                res.index = COL_IDX_W'(j);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/mkscan_if.sv =====
// Handshake interfaces for the sample, key and configuration channels of the scanner.
`timescale 1ns / 1ps
`default_nettype none
interface mkscan_sample_if
    import mkscan_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_levels;
    logic [COL_W-1:0] column_levels;

    modport source (output valid, output row_levels, output column_levels, input ready);
    modport sink   (input valid, input row_levels, input column_levels, output ready);
endinterface

interface mkscan_key_if
    import mkscan_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              sense_columns;
    logic [CODE_W-1:0] key_value;
    logic              key_event;

    modport source (output valid, output sense_columns, output key_value, output key_event,
                    input ready);
    modport sink   (input valid, input sense_columns, input key_value, input key_event,
                    output ready);
endinterface

interface mkscan_cfg_if
    import mkscan_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/matrix_keypad_line_reversal_scanner.sv =====
// Top level of the matrix keypad scanner that works by line reversal.
//
//   Channel  | Direction | Beat contents
//   ---------+-----------+---------------------------------------------
//   samples  | in        | row_levels[4:0], column_levels[3:0]
//   keys     | out       | sense_columns, key_value[4:0], key_event
//   cfg      | in        | index[0] (0 debounce_limit, 1 release_ticks), data[15:0]
//
// Each sample beat yields exactly one key beat, registered when the sample is accepted.
// A new sample is taken in every cycle in which the key register is empty or being emptied.
// The sample is folded into the scan state in the cycle it is accepted, so the key
// register is the only stage; a stalled key beat holds the sample channel off.
// Reset clears all scan state and restores the register defaults; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
module matrix_keypad_line_reversal_scanner
    import mkscan_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    mkscan_sample_if.sink     samples,
    mkscan_key_if.source      keys,
    mkscan_cfg_if.sink        cfg
);

    logic [HITS_W-1:0]    debounce_limit_reg;
    logic [RELEASE_W-1:0] release_ticks_reg;

    logic [HITS_W-1:0]    row_hits_reg, row_hits_next;
    logic [HITS_W-1:0]    column_hits_reg, column_hits_next;
    logic [ROW_IDX_W-1:0] row_index_reg, row_index_next;
    logic [COL_IDX_W-1:0] column_index_reg, column_index_next;
    logic                 pending_flag_reg, pending_flag_next;
    logic [CODE_W-1:0]    pending_code_reg, pending_code_next;
    logic [RELEASE_W-1:0] release_count_reg, release_count_next;
    logic [CODE_W-1:0]    published_code_reg, published_code_next;

    logic                 out_valid_reg;
    logic                 sense_columns_reg, sense_columns_next;
    logic                 key_event_reg, key_event_next;

    logic                 sample_accept;
    logic                 confirmed;
    row_hit_t             row_hit;
    col_hit_t             col_hit;
    logic [RELEASE_W-1:0] release_inc;
    logic [CODE_W-1:0]    code_sum;

    assign samples.ready = !out_valid_reg || keys.ready;
    assign sample_accept = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    assign keys.valid         = out_valid_reg;
    assign keys.sense_columns = sense_columns_reg;
    assign keys.key_value     = published_code_reg;
    assign keys.key_event     = key_event_reg;

    assign row_hit     = lowest_low_row(samples.row_levels);
    assign col_hit     = lowest_low_col(samples.column_levels);
    assign release_inc = release_count_reg + RELEASE_W'(1);
    assign code_sum    = CODE_W'(row_index_reg) * CODE_W'(NUM_COLUMNS)
                         + CODE_W'(column_index_reg) + CODE_W'(1);

    always_comb
    begin
        row_hits_next       = row_hits_reg;
        column_hits_next    = column_hits_reg;
        row_index_next      = row_index_reg;
        column_index_next   = column_index_reg;
        pending_flag_next   = pending_flag_reg;
        pending_code_next   = pending_code_reg;
        release_count_next  = release_count_reg;
        published_code_next = published_code_reg;
        key_event_next      = 1'b0;
        confirmed           = 1'b0;

        if (row_hits_reg <= debounce_limit_reg)
        begin
            if (row_hit.found)
            begin
                if (row_hits_reg != HITS_MAX)
                begin
                    row_hits_next = row_hits_reg + HITS_W'(1);
                end
                row_index_next = row_hit.index;
            end
            else
            begin
                row_hits_next     = '0;
                column_hits_next  = '0;
                row_index_next    = '0;
                column_index_next = '0;
            end
        end
        else if (column_hits_reg <= debounce_limit_reg)
        begin
            if (col_hit.found)
            begin
                if (column_hits_reg != HITS_MAX)
                begin
                    column_hits_next = column_hits_reg + HITS_W'(1);
                end
                column_index_next = col_hit.index;
            end
            else
            begin
                row_hits_next     = '0;
                column_hits_next  = '0;
                row_index_next    = '0;
                column_index_next = '0;
            end
        end
        else
        begin
            pending_code_next  = code_sum;
            pending_flag_next  = 1'b1;
            release_count_next = '0;
            confirmed          = 1'b1;
            row_hits_next      = '0;
            column_hits_next   = '0;
            row_index_next     = '0;
            column_index_next  = '0;
        end

        // A pending key is published once it has gone unconfirmed for long enough.
        if (pending_flag_reg && !confirmed)
        begin
            release_count_next = release_inc;
            if (release_inc >= release_ticks_reg)
            begin
                published_code_next = pending_code_reg;
                release_count_next  = '0;
                pending_flag_next   = 1'b0;
                key_event_next      = 1'b1;
            end
        end

        sense_columns_next = (row_hits_next > debounce_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= DEBOUNCE_RESET;
            release_ticks_reg  <= RELEASE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg.data[HITS_W-1:0];
                REG_RELEASE_TICKS:  release_ticks_reg  <= cfg.data[RELEASE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_hits_reg       <= '0;
            column_hits_reg    <= '0;
            row_index_reg      <= '0;
            column_index_reg   <= '0;
            pending_flag_reg   <= 1'b0;
            pending_code_reg   <= '0;
            release_count_reg  <= '0;
            published_code_reg <= '0;
            sense_columns_reg  <= 1'b0;
            key_event_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (sample_accept)
            begin
                row_hits_reg       <= row_hits_next;
                column_hits_reg    <= column_hits_next;
                row_index_reg      <= row_index_next;
                column_index_reg   <= column_index_next;
                pending_flag_reg   <= pending_flag_next;
                pending_code_reg   <= pending_code_next;
                release_count_reg  <= release_count_next;
                published_code_reg <= published_code_next;
                sense_columns_reg  <= sense_columns_next;
                key_event_reg      <= key_event_next;
                out_valid_reg      <= 1'b1;
            end
            else if (keys.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mkscan_checker.sv =====
// Port-level checker for the keypad scanner and the bind that attaches it.
`timescale 1ns / 1ps
`default_nettype none
module mkscan_checker
    import mkscan_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              in_ready,
    input wire              out_valid,
    input wire              out_ready,
    input wire              sense_columns,
    input wire [CODE_W-1:0] key_value,
    input wire              key_event
);

    // The sample side is never held off while the key register is empty.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("sample channel stalled with an empty key register");

    // A published key always carries a real code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event |-> key_value != '0)
        else $error("key event without a key code");

    // Codes never exceed the size of the matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_value <= CODE_W'(NUM_ROWS * NUM_COLUMNS))
        else $error("key code outside the matrix");

    // A stalled key beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_value)
            && $stable(key_event) && $stable(sense_columns))
        else $error("stalled key beat changed");

endmodule

bind matrix_keypad_line_reversal_scanner mkscan_checker u_mkscan_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (samples.ready),
    .out_valid     (keys.valid),
    .out_ready     (keys.ready),
    .sense_columns (keys.sense_columns),
    .key_value     (keys.key_value),
    .key_event     (keys.key_event)
);
`default_nettype wire
